// ===== hw/rtl/rsst_pkg.sv =====
// Shared types and codes for the range-sum segment tree.
`timescale 1ns / 1ps

package rsst_pkg;

  localparam int SUM_W = 48;
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int CNT_W = 11;

  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_SUB   = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LEAF_RD,
    S_LEAF_WR,
    S_SIB_RD,
    S_PAR_WR,
    S_Q_TEST,
    S_Q_LACC,
    S_Q_RACC,
    S_FIN
  } state_t;

  // operand pick for the shared adder
  typedef enum logic [1:0] {
    ADD_LEAF,
    ADD_PATH,
    ADD_ACC
  } add_sel_t;

endpackage

// ===== hw/rtl/range_sum_segment_tree.sv =====
// Update: reads and writes the leaf, then at each level up the path reads the sibling and
// writes the parent. A query makes at most two node reads per level. Faulted commands go
// straight to the result. One command at a time through the single RAM port; the next
// command is taken while the previous result waits on the output.
// Reset: synchronous; afterwards a clearing pass zeroes all 2*LEAVES nodes, one per cycle,
// while s_tready stays low. element_count resets to 1024.
`timescale 1ns / 1ps

module range_sum_segment_tree #(
  parameter int LEAVES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [rsst_pkg::CNT_W-1:0] cfg_data,   // element_count
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // index_lo[9:0], index_hi[19:10], value[51:20], zeros
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // range_sum[47:0], status[49:48], zeros
);

  import rsst_pkg::*;

  localparam int DEPTH = 2 * LEAVES;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = AW + 1;

  state_t state, state_next;
  add_sel_t add_sel;

  logic [CNT_W-1:0] element_count;
  logic [1:0]       cmd;
  logic [1:0]       status_r;
  logic [VAL_W-1:0] value_r;
  logic [AW-1:0]    p;
  logic [PW-1:0]    l, r;
  logic [SUM_W-1:0] acc, cur;
  logic [AW-1:0]    clr_addr;
  logic [SUM_W-1:0] res_sum;
  logic [1:0]       res_status;

  logic [1:0]       in_cmd;
  logic [IDX_W-1:0] in_lo, in_hi;
  logic [VAL_W-1:0] in_value;
  logic             lo_ok, hi_ok, accept, out_free;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_addr;
  logic [SUM_W-1:0] mem_wdata, mem_q;
  logic [SUM_W-1:0] val_ext, op_a, op_b, add_res;
  logic             add_sub;

  assign in_cmd   = s_tuser;
  assign in_lo    = s_tdata[9:0];
  assign in_hi    = s_tdata[19:10];
  assign in_value = s_tdata[51:20];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign lo_ok = ({1'b0, in_lo} < element_count) && (32'(in_lo) < LEAVES);
  assign hi_ok = ({1'b0, in_hi} < element_count) && (32'(in_hi) < LEAVES);

  assign val_ext = {{(SUM_W-VAL_W){value_r[VAL_W-1]}}, value_r};

  // shared 48-bit adder
  always_comb begin
    op_a    = acc;
    op_b    = mem_q;
    add_sub = 1'b0;
    case (add_sel)
      ADD_LEAF: begin
        op_a    = mem_q;
        op_b    = val_ext;
        add_sub = (cmd == CMD_SUB);
      end
      ADD_PATH: begin
        op_a = cur;
        op_b = mem_q;
      end
      ADD_ACC: begin
        op_a = acc;
        op_b = mem_q;
      end
      default: begin
        op_a = acc;
        op_b = mem_q;
      end
    endcase
  end

  assign add_res = op_a + (add_sub ? ~op_b : op_b) + {{(SUM_W-1){1'b0}}, add_sub};

  rsst_ram #(
    .DEPTH (DEPTH),
    .DATA_W(SUM_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_q)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_QUERY) begin
            if (!lo_ok || !hi_ok || in_lo > in_hi) state_next = S_FIN;
            else state_next = S_Q_TEST;
          end else if (!lo_ok) begin
            state_next = S_FIN;
          end else begin
            state_next = S_LEAF_RD;
          end
        end
      end
      S_LEAF_RD: state_next = S_LEAF_WR;
      S_LEAF_WR: state_next = S_SIB_RD;
      S_SIB_RD:  state_next = S_PAR_WR;
      S_PAR_WR: begin
        if ((p >> 1) == AW'(1)) state_next = S_FIN;
        else state_next = S_SIB_RD;
      end
      S_Q_TEST: begin
        if (l >= r) state_next = S_FIN;
        else if (l[0]) state_next = S_Q_LACC;
        else if (r[0]) state_next = S_Q_RACC;
      end
      S_Q_LACC: begin
        if (r[0]) state_next = S_Q_RACC;
        else state_next = S_Q_TEST;
      end
      S_Q_RACC: state_next = S_Q_TEST;
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // RAM and adder control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = p;
    mem_wdata = add_res;
    add_sel   = ADD_ACC;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
      end
      S_LEAF_RD: begin
        mem_re   = 1'b1;
        mem_addr = p;
      end
      S_LEAF_WR: begin
        mem_we    = 1'b1;
        mem_addr  = p;
        add_sel   = ADD_LEAF;
        mem_wdata = (cmd == CMD_LOAD) ? val_ext : add_res;
      end
      S_SIB_RD: begin
        mem_re   = 1'b1;
        mem_addr = p ^ AW'(1);
      end
      S_PAR_WR: begin
        mem_we   = 1'b1;
        mem_addr = p >> 1;
        add_sel  = ADD_PATH;
      end
      S_Q_TEST: begin
        if (l < r && l[0]) begin
          mem_re   = 1'b1;
          mem_addr = l[AW-1:0];
        end else if (l < r && r[0]) begin
          mem_re   = 1'b1;
          mem_addr = AW'(r - PW'(1));
        end
      end
      S_Q_LACC: begin
        add_sel = ADD_ACC;
        if (r[0]) begin
          mem_re   = 1'b1;
          mem_addr = AW'(r - PW'(1));
        end
      end
      S_Q_RACC: add_sel = ADD_ACC;
      default: begin
        mem_we = 1'b0;
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      element_count <= COUNT_RESET;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) element_count <= cfg_data;
      if (state == S_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (state == S_FIN && out_free) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd     <= in_cmd;
          value_r <= in_value;
          acc     <= '0;
          p       <= AW'(in_lo) + AW'(LEAVES);
          l       <= PW'(in_lo) + PW'(LEAVES);
          r       <= PW'(in_hi) + PW'(LEAVES) + PW'(1);
          if (in_cmd == CMD_QUERY) begin
            if (!lo_ok || !hi_ok) status_r <= STAT_RANGE;
            else if (in_lo > in_hi) status_r <= STAT_EMPTY;
            else status_r <= STAT_OK;
          end else begin
            status_r <= lo_ok ? STAT_OK : STAT_RANGE;
          end
        end
      end
      S_LEAF_WR: cur <= mem_wdata;
      S_PAR_WR: begin
        cur <= add_res;
        p   <= p >> 1;
      end
      S_Q_TEST: begin
        if (l < r && !l[0] && !r[0]) begin
          l <= l >> 1;
          r <= r >> 1;
        end
      end
      S_Q_LACC: begin
        acc <= add_res;
        if (r[0]) begin
          l <= l + PW'(1);
        end else begin
          l <= (l + PW'(1)) >> 1;
          r <= r >> 1;
        end
      end
      S_Q_RACC: begin
        // r is odd here, so (r-1)>>1 equals r>>1
        acc <= add_res;
        l   <= l >> 1;
        r   <= r >> 1;
      end
      S_FIN: begin
        if (out_free) begin
          res_sum    <= acc;
          res_status <= status_r;
        end
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

  assign m_tdata = {6'b0, res_status, res_sum};

endmodule

// ===== hw/rtl/rsst_ram.sv =====
// Single-port tree node RAM with registered read data.
`timescale 1ns / 1ps

module rsst_ram #(
  parameter int DEPTH  = 2048,
  parameter int DATA_W = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== verif/range_sum_checker.sv =====
// Watches the command and result streams, predicts each result and compares it.
`timescale 1ns / 1ps

module range_sum_checker #(
  parameter int LEAVES = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rsst_pkg::CNT_W-1:0] cfg_data,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [55:0]                s_tdata,
  input  logic [1:0]                 s_tuser,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [55:0]                m_tdata,
  output int                         errors,
  output int                         pending
);

  import rsst_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0] range_sum;
    logic [1:0]       status;
  } answer_t;

  logic [SUM_W-1:0] entry [LEAVES];
  logic [CNT_W-1:0] active_count;
  answer_t          answer_q [$];

  function automatic bit in_use(logic [IDX_W-1:0] idx);
    return (idx < active_count) && (idx < LEAVES);
  endfunction

  // Applies one command to the entry mirror and returns the answer it should give.
  function automatic answer_t run_command(logic [1:0] cmd, logic [IDX_W-1:0] lo,
                                          logic [IDX_W-1:0] hi, logic [VAL_W-1:0] val);
    answer_t          ans;
    logic [SUM_W-1:0] amount;
    logic [SUM_W-1:0] acc;
    int               i;
    ans.range_sum = '0;
    ans.status    = STAT_OK;
    amount = {{(SUM_W-VAL_W){val[VAL_W-1]}}, val};
    if (cmd == CMD_QUERY) begin
      // out-of-range wins over an empty range
      if (!in_use(lo) || !in_use(hi)) begin
        ans.status = STAT_RANGE;
      end else if (lo > hi) begin
        ans.status = STAT_EMPTY;
      end else begin
        acc = '0;
        for (i = int'(lo); i <= int'(hi); i++) acc = acc + entry[i];
        ans.range_sum = acc;
      end
    end else if (!in_use(lo)) begin
      ans.status = STAT_RANGE;
    end else begin
      case (cmd)
        CMD_LOAD: entry[lo] = amount;
        CMD_ADD:  entry[lo] = entry[lo] + amount;
        default:  entry[lo] = entry[lo] - amount;
      endcase
    end
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    answer_t got;
    answer_t want;
    bit      fail;
    int      k;
    fail = 1'b0;
    if (rst) begin
      for (k = 0; k < LEAVES; k++) entry[k] = '0;
      active_count = COUNT_RESET;
      answer_q.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.range_sum = m_tdata[SUM_W-1:0];
        got.status    = m_tdata[SUM_W+1:SUM_W];
        if (answer_q.size() == 0) begin
          fail = 1'b1;
          if (errors < 10)
            $display("checker: unexpected result sum %h status %0d",
                     got.range_sum, got.status);
        end else begin
          want = answer_q.pop_front();
          if (got !== want) begin
            fail = 1'b1;
            if (errors < 10)
              $display("checker: mismatch sum %h status %0d, expected sum %h status %0d",
                       got.range_sum, got.status, want.range_sum, want.status);
          end
        end
      end
      if (s_tvalid && s_tready)
        answer_q.push_back(run_command(s_tuser, s_tdata[IDX_W-1:0],
                                       s_tdata[2*IDX_W-1:IDX_W],
                                       s_tdata[2*IDX_W+VAL_W-1:2*IDX_W]));
      if (cfg_we) active_count = cfg_data;
      pending <= answer_q.size();
      if (fail) errors <= errors + 1;
    end
  end

endmodule

// ===== verif/tb.sv =====
// Stimulus and verdict for the range-sum segment tree.
`timescale 1ns / 1ps

module tb;
  import rsst_pkg::*;

  localparam int LEAVES = 1024;
  localparam int DRAIN  = 64;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             cfg_we   = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;
  logic             s_tvalid = 1'b0;
  logic [55:0]      s_tdata  = '0;
  logic [1:0]       s_tuser  = '0;
  logic             m_tready = 1'b0;
  logic             s_tready;
  logic             m_tvalid;
  logic [55:0]      m_tdata;

  int               errors;
  int               pending;
  int               src_idle = 0;
  int               dst_idle = 0;
  logic [CNT_W-1:0] count_now = COUNT_RESET;

  always #6 clk = ~clk;

  range_sum_segment_tree #(.LEAVES(LEAVES)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  range_sum_checker #(.LEAVES(LEAVES)) i_checker (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending)
  );

  always @(posedge clk) m_tready <= ($urandom_range(99) >= dst_idle);

  // valid stays high across back-to-back transfers; it drops only for a gap
  task automatic send_cmd(logic [1:0] cmd, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi,
                          logic [VAL_W-1:0] val);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {4'b0, val, hi, lo};
    do @(posedge clk); while (!s_tready);
  endtask

  // register writes only once every result is back
  task automatic set_count(logic [CNT_W-1:0] cnt);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= cnt;
    @(posedge clk);
    cfg_we    <= 1'b0;
    count_now = cnt;
  endtask

  function automatic logic [IDX_W-1:0] pick_index(int span);
    if (span == 0 || $urandom_range(9) == 0) return IDX_W'($urandom);
    return IDX_W'($urandom_range(span - 1));
  endfunction

  task automatic send_random(int n);
    logic [1:0]       cmd;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] swap;
    logic [VAL_W-1:0] val;
    int               span;
    repeat (n) begin
      span = (count_now > LEAVES) ? LEAVES : int'(count_now);
      cmd  = 2'($urandom_range(3));
      lo   = pick_index(span);
      hi   = pick_index(span);
      // mostly proper ranges, a few empty ones
      if (cmd == CMD_QUERY && lo > hi && $urandom_range(3) != 0) begin
        swap = lo;
        lo   = hi;
        hi   = swap;
      end
      case ($urandom_range(7))
        0:       val = 32'h7fff_ffff;
        1:       val = 32'h8000_0000;
        2:       val = '0;
        default: val = $urandom;
      endcase
      send_cmd(cmd, lo, hi, val);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // clearing pass holds s_tready low
    while (!s_tready) @(posedge clk);

    src_idle = 30;
    dst_idle = 68;
    set_count(COUNT_RESET);
    send_cmd(CMD_LOAD,  10'd0,    10'd0,    32'h7fff_ffff);
    send_cmd(CMD_LOAD,  10'd1023, 10'd1023, 32'h8000_0000);
    send_cmd(CMD_LOAD,  10'd512,  10'd0,    32'hffff_ffff);
    send_cmd(CMD_QUERY, 10'd0,    10'd1023, 32'h0);
    send_cmd(CMD_ADD,   10'd0,    10'd1023, 32'h7fff_ffff);
    send_cmd(CMD_SUB,   10'd1023, 10'd0,    32'h8000_0000);
    send_cmd(CMD_SUB,   10'd1,    10'd0,    32'h7fff_ffff);
    send_cmd(CMD_LOAD,  10'd341,  10'd682,  32'h5555_5555);
    send_cmd(CMD_QUERY, 10'd0,    10'd1023, 32'hffff_ffff);
    send_cmd(CMD_QUERY, 10'd0,    10'd0,    32'h0);
    send_cmd(CMD_QUERY, 10'd1023, 10'd1023, 32'h0);
    send_cmd(CMD_QUERY, 10'd1023, 10'd0,    32'h0);
    send_cmd(CMD_QUERY, 10'd1,    10'd1022, 32'h0);
    send_random(400);

    set_count(11'd1);
    send_cmd(CMD_LOAD,  10'd1,    10'd0,    32'h1234_5678);
    send_cmd(CMD_QUERY, 10'd0,    10'd1,    32'h0);
    send_cmd(CMD_QUERY, 10'd1,    10'd0,    32'h0);
    send_cmd(CMD_LOAD,  10'd0,    10'd0,    32'h8000_0000);
    send_cmd(CMD_SUB,   10'd0,    10'd0,    32'h7fff_ffff);
    send_cmd(CMD_QUERY, 10'd0,    10'd0,    32'h0);
    send_random(80);

    src_idle = 68;
    dst_idle = 30;
    set_count(11'd2047);
    send_random(400);
    set_count(11'd37);
    send_random(300);

    src_idle = 0;
    dst_idle = 0;
    // nothing is in range with a zero count
    set_count(11'd0);
    send_cmd(CMD_LOAD,  10'd0,    10'd0,    32'h1);
    send_cmd(CMD_ADD,   10'd1023, 10'd0,    32'h1);
    send_cmd(CMD_QUERY, 10'd0,    10'd0,    32'h0);
    send_cmd(CMD_QUERY, 10'd1023, 10'd0,    32'h0);
    send_random(40);
    set_count(11'd513);
    send_random(300);
    set_count(COUNT_RESET);
    send_random(100);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rsst_pkg.sv
hw/rtl/rsst_ram.sv
hw/rtl/range_sum_segment_tree.sv
verif/range_sum_checker.sv
verif/tb.sv
